FILE: rtl/wfpa_pkg.sv
`timescale 1ns / 1ps
// shared constants and codes of the worst-fit partition allocator
package wfpa_pkg;

   localparam int NUM_BLOCKS_DEF = 16;
   localparam int SIZE_W         = 16;
   localparam int BIDX_W         = 4;
   localparam int STATUS_W       = 2;
   localparam int REQ_DATA_W     = 24;   // block_index + size_value, padded to bytes
   localparam int RSP_DATA_W     = 24;   // granted_index + remaining_hole, padded to bytes

   // request kinds carried on req_tuser
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // result kinds carried on rsp_tuser
   typedef enum logic [STATUS_W-1:0] {
      STAT_LOADED  = 2'd0,
      STAT_GRANTED = 2'd1,
      STAT_NONE    = 2'd2
   } status_type;

endpackage

FILE: rtl/worst_fit_partition_allocator.sv
`timescale 1ns / 1ps
// worst-fit fixed-partition allocator: top level
//
// usage
//  - req channel: one transaction is a load (req_tuser = 0: block_index and
//    size_value set one partition's size and mark it free) or an allocation
//    request (req_tuser = 1: size_value is the requested size)
//  - rsp channel: exactly one transaction per request transaction, in order;
//    rsp_tuser carries the status, rsp_tdata the granted index and leftover hole
//  - a load sets its result in the result stage, from which it moves into the
//    output register; the next transaction is taken once it has moved on
//  - a request walks the size memory one entry per cycle through one comparator,
//    then passes the tail state (last compare), the decide state (grant
//    decision) and the result stage; the next transaction is taken once its
//    result has moved into the output register
//  - the result sits in an output register; the next transaction is taken while
//    a finished result waits, and a stalled rsp side only holds back the block
//    once a second result is ready
//  - reset (synchronous, active high) marks every partition used and empties
//    the pipeline; the size memory is not cleared since a size is read only
//    behind its free bit, which is set only by a load
module worst_fit_partition_allocator #(
   parameter int NUM_BLOCKS = wfpa_pkg::NUM_BLOCKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [wfpa_pkg::REQ_DATA_W-1:0] req_tdata,   // [3:0] block_index, [19:4] size_value
   input  logic [0:0]                      req_tuser,   // [0] opcode
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [wfpa_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [3:0] granted_index, [19:4] remaining_hole
   output logic [wfpa_pkg::STATUS_W-1:0]   rsp_tuser    // [1:0] status
);

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int SIZE_W = wfpa_pkg::SIZE_W;
   localparam int BIDX_W = wfpa_pkg::BIDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_DECIDE,
      ST_DONE
   } state_type;

   state_type                state_ff;

   // captured request
   logic [SIZE_W-1:0]        req_size_ff;

   // partition state: free bits in flops, sizes in a memory
   logic [NUM_BLOCKS-1:0]    free_ff;
   logic [SIZE_W-1:0]        size_mem [NUM_BLOCKS];
   logic [SIZE_W-1:0]        rd_data_ff;

   // scan pipeline
   logic [IDX_W-1:0]         cnt_ff;
   logic                     cmp_vld_ff;
   logic [IDX_W-1:0]         cmp_idx_ff;

   // running best
   logic                     best_found_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic [SIZE_W-1:0]        best_size_ff;

   // finished result waiting for the output register
   wfpa_pkg::status_type     res_status_ff;
   logic [BIDX_W-1:0]        res_index_ff;
   logic [SIZE_W-1:0]        res_hole_ff;

   // output register
   logic                     rsp_tvalid_ff;
   logic [BIDX_W-1:0]        rsp_index_ff;
   logic [SIZE_W-1:0]        rsp_hole_ff;
   wfpa_pkg::status_type     rsp_status_ff;

   // input unpacking
   logic                     in_op;
   logic [BIDX_W-1:0]        in_bidx;
   logic [SIZE_W-1:0]        in_size;
   logic                     in_accept;
   logic                     load_in_range;
   logic [IDX_W+BIDX_W-1:0]  load_addr_wide;
   logic [IDX_W-1:0]         load_addr;
   logic                     mem_wr_en;

   // scan compare and grant
   logic                     cmp_take;
   logic                     fits;
   logic [IDX_W+BIDX_W-1:0]  grant_wide;
   logic                     out_load;

   assign in_op     = req_tuser[0];
   assign in_bidx   = req_tdata[BIDX_W-1:0];
   assign in_size   = req_tdata[BIDX_W+SIZE_W-1:BIDX_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign in_accept = req_tvalid && req_tready;

   // loads beyond the partition count are dropped
   assign load_in_range  = (32'(in_bidx) < NUM_BLOCKS);
   assign load_addr_wide = (IDX_W+BIDX_W)'(in_bidx);
   assign load_addr      = load_addr_wide[IDX_W-1:0];
   assign mem_wr_en      = in_accept && (in_op == wfpa_pkg::OP_LOAD) && load_in_range;

   // one comparator: strictly larger wins, so ties keep the lower index
   assign cmp_take = cmp_vld_ff && free_ff[cmp_idx_ff] &&
                     (!best_found_ff || (rd_data_ff > best_size_ff));

   assign fits       = best_found_ff && (best_size_ff >= req_size_ff);
   assign grant_wide = (IDX_W+BIDX_W)'(best_idx_ff);

   // result stage moves into the output register when that is empty or draining
   assign out_load = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // partition size memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         size_mem[load_addr] <= in_size;
      end
      rd_data_ff <= size_mem[cnt_ff];
   end

   // control, free bits and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_ff       <= '0;
         cnt_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= (state_ff == ST_SCAN);
         cmp_idx_ff <= cnt_ff;

         if (cmp_take) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= cmp_idx_ff;
            best_size_ff  <= rd_data_ff;
         end

         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_status_ff <= res_status_ff;
            rsp_index_ff  <= res_index_ff;
            rsp_hole_ff   <= res_hole_ff;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (in_accept) begin
                  req_size_ff <= in_size;
                  if (in_op == wfpa_pkg::OP_LOAD) begin
                     if (load_in_range) begin
                        free_ff[load_addr] <= 1'b1;
                     end
                     res_status_ff <= wfpa_pkg::STAT_LOADED;
                     res_index_ff  <= '0;
                     res_hole_ff   <= '0;
                     state_ff      <= ST_DONE;
                  end else begin
                     cnt_ff        <= '0;
                     best_found_ff <= 1'b0;
                     state_ff      <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (cnt_ff == IDX_W'(NUM_BLOCKS - 1)) begin
                  state_ff <= ST_TAIL;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_TAIL: begin
               // last entry is compared in this cycle
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (fits) begin
                  free_ff[best_idx_ff] <= 1'b0;
                  res_status_ff <= wfpa_pkg::STAT_GRANTED;
                  res_index_ff  <= grant_wide[BIDX_W-1:0];
                  res_hole_ff   <= best_size_ff - req_size_ff;
               end else begin
                  res_status_ff <= wfpa_pkg::STAT_NONE;
                  res_index_ff  <= '0;
                  res_hole_ff   <= '0;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(wfpa_pkg::RSP_DATA_W-BIDX_W-SIZE_W){1'b0}}, rsp_hole_ff, rsp_index_ff};

endmodule

FILE: rtl/wfpa_checker.sv
`timescale 1ns / 1ps
// port-level checker for the worst-fit partition allocator, with its bind
module wfpa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [wfpa_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [0:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [wfpa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [wfpa_pkg::STATUS_W-1:0]   rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == wfpa_pkg::STAT_LOADED) ||
                     (rsp_tuser == wfpa_pkg::STAT_GRANTED) ||
                     (rsp_tuser == wfpa_pkg::STAT_NONE))
      else $error("undefined status");

   // index and hole are zero unless granted
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != wfpa_pkg::STAT_GRANTED) |-> (rsp_tdata == '0))
      else $error("nonzero payload without grant");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a taken transaction is never answered in the very next cycle by a new result
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared without latency");

endmodule

bind worst_fit_partition_allocator wfpa_checker u_wfpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: sim/wfpa_checker.sv
`timescale 1ns / 1ps
// scoreboard for the worst-fit partition allocator: predicts and compares results
module wfpa_scoreboard #(
   parameter int NUM_BLOCKS = wfpa_pkg::NUM_BLOCKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [wfpa_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [wfpa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [wfpa_pkg::STATUS_W-1:0]   rsp_tuser,
   output int                              fail_count,
   output int                              outcomes_pending,
   output int                              loads_seen,
   output int                              grants_seen,
   output int                              refusals_seen
);

   localparam int SIZE_W = wfpa_pkg::SIZE_W;
   localparam int BIDX_W = wfpa_pkg::BIDX_W;

   typedef struct packed {
      wfpa_pkg::status_type status;
      logic [BIDX_W-1:0]    index;
      logic [SIZE_W-1:0]    hole;
   } alloc_outcome_type;

   logic [SIZE_W-1:0] part_size [NUM_BLOCKS];
   logic              part_free [NUM_BLOCKS];
   alloc_outcome_type outcome_queue [$];
   int                failures;
   int                n_loads;
   int                n_grants;
   int                n_refusals;

   // worst fit: largest free partition, lowest index on a tie
   task automatic compute_allocation(input logic op, input logic [BIDX_W-1:0] bidx,
                                     input logic [SIZE_W-1:0] sz,
                                     output alloc_outcome_type res);
      bit found;
      int best;
      found = 0;
      best  = 0;
      res   = '{status: wfpa_pkg::STAT_LOADED, index: '0, hole: '0};
      if (op == wfpa_pkg::OP_LOAD) begin
         if (int'(bidx) < NUM_BLOCKS) begin
            part_size[bidx] = sz;
            part_free[bidx] = 1'b1;
         end
         return;
      end
      for (int j = 0; j < NUM_BLOCKS; j++) begin
         if (part_free[j] && (!found || part_size[j] > part_size[best])) begin
            best  = j;
            found = 1;
         end
      end
      if (found && part_size[best] >= sz) begin
         part_free[best] = 1'b0;
         res.status = wfpa_pkg::STAT_GRANTED;
         res.index  = best[BIDX_W-1:0];
         res.hole   = part_size[best] - sz;
      end else begin
         res.status = wfpa_pkg::STAT_NONE;
      end
   endtask

   always @(posedge clock) begin
      alloc_outcome_type exp_res;
      alloc_outcome_type got_res;
      if (reset) begin
         for (int j = 0; j < NUM_BLOCKS; j++) begin
            part_free[j] = 1'b0;
            part_size[j] = '0;
         end
         outcome_queue.delete();
         failures   = 0;
         n_loads    = 0;
         n_grants   = 0;
         n_refusals = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_res.status = wfpa_pkg::status_type'(rsp_tuser);
            got_res.index  = rsp_tdata[BIDX_W-1:0];
            got_res.hole   = rsp_tdata[BIDX_W +: SIZE_W];
            if (outcome_queue.size() == 0) begin
               if (failures < 10)
                  $display("%0t: result with none outstanding: status %0d index %0d hole %h",
                           $time, rsp_tuser, got_res.index, got_res.hole);
               failures++;
            end else begin
               exp_res = outcome_queue.pop_front();
               if (rsp_tuser !== exp_res.status || got_res.index !== exp_res.index ||
                   got_res.hole !== exp_res.hole) begin
                  if (failures < 10)
                     $display("%0t: expected status %0d index %0d hole %h, got %0d %0d %h",
                              $time, exp_res.status, exp_res.index, exp_res.hole,
                              rsp_tuser, got_res.index, got_res.hole);
                  failures++;
               end
               case (exp_res.status)
                  wfpa_pkg::STAT_LOADED:  n_loads++;
                  wfpa_pkg::STAT_GRANTED: n_grants++;
                  default:                n_refusals++;
               endcase
            end
         end
         if (req_tvalid && req_tready) begin
            compute_allocation(req_tuser[0], req_tdata[BIDX_W-1:0],
                               req_tdata[BIDX_W +: SIZE_W], exp_res);
            outcome_queue.push_back(exp_res);
         end
      end
      fail_count       <= failures;
      outcomes_pending <= outcome_queue.size();
      loads_seen       <= n_loads;
      grants_seen      <= n_grants;
      refusals_seen    <= n_refusals;
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// stimulus, clocking and verdict for the worst-fit partition allocator
module testbench;

   localparam int RANDOM_ITEMS   = 1025;
   localparam int WATCHDOG_LIMIT = 1000;   // far above one request with the largest random gaps on both channels
   localparam int DRAIN_CYCLES   = 40;
   localparam int SIZE_W         = wfpa_pkg::SIZE_W;
   localparam int BIDX_W         = wfpa_pkg::BIDX_W;
   localparam int REQ_DATA_W     = wfpa_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W     = wfpa_pkg::RSP_DATA_W;
   localparam int STATUS_W       = wfpa_pkg::STATUS_W;
   localparam int NUM_BLOCKS     = wfpa_pkg::NUM_BLOCKS_DEF;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;    // [3:0] block_index, [19:4] size_value
   logic [0:0]            req_tuser;    // [0] opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // [3:0] granted_index, [19:4] remaining_hole
   logic [STATUS_W-1:0]   rsp_tuser;    // [1:0] status

   int fail_count;
   int outcomes_pending;
   int loads_seen;
   int grants_seen;
   int refusals_seen;
   int items_sent;
   int idle_cycles;
   bit calm_phase;   // both sides run without gaps while set

   worst_fit_partition_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   wfpa_scoreboard u_scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .fail_count       (fail_count),
      .outcomes_pending (outcomes_pending),
      .loads_seen       (loads_seen),
      .grants_seen      (grants_seen),
      .refusals_seen    (refusals_seen)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int draw_gap();
      return calm_phase ? 0 : $urandom_range(0, 8);
   endfunction

   // partition sizes: extremes, tiny values, repeated values that force ties, anything
   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return SIZE_W'($urandom_range(0, 15));
         3:       return SIZE_W'(1000 * $urandom_range(1, 3));
         default: return SIZE_W'($urandom);
      endcase
   endfunction

   // request sizes lean small so that grants stay frequent
   function automatic logic [SIZE_W-1:0] pick_request();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return SIZE_W'($urandom_range(0, 255));
         2:       return SIZE_W'($urandom_range(0, 4095));
         3:       return SIZE_W'(1000 * $urandom_range(1, 3));
         default: return SIZE_W'($urandom);
      endcase
   endfunction

   // present one transaction after a random gap and hold it until it is taken
   task automatic send_item(input logic op, input logic [BIDX_W-1:0] bidx,
                            input logic [SIZE_W-1:0] sz);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - SIZE_W - BIDX_W){1'b0}}, sz, bidx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // result side: random stall before each transaction
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                  idle_cycles, outcomes_pending);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int random_sent;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = wfpa_pkg::OP_LOAD;
      items_sent  = 0;
      calm_phase  = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing free yet: both a plain and a zero-size request are refused
      send_item(wfpa_pkg::OP_REQUEST, 4'hF, 16'h0010);
      send_item(wfpa_pkg::OP_REQUEST, 4'h0, 16'h0000);
      // zero-size request takes a free partition of size zero
      send_item(wfpa_pkg::OP_LOAD,    4'h0, 16'h0000);
      send_item(wfpa_pkg::OP_REQUEST, 4'hA, 16'h0000);
      // equal largest sizes: lowest index wins, then the other one
      send_item(wfpa_pkg::OP_LOAD,    4'hF, 16'hFFFF);
      send_item(wfpa_pkg::OP_LOAD,    4'h3, 16'hFFFF);
      send_item(wfpa_pkg::OP_REQUEST, 4'h5, 16'hFFFF);
      send_item(wfpa_pkg::OP_REQUEST, 4'h0, 16'h0000);
      // everything used again
      send_item(wfpa_pkg::OP_REQUEST, 4'h0, 16'h0001);
      // largest free too small, then an exact fit
      send_item(wfpa_pkg::OP_LOAD,    4'h5, 16'd100);
      send_item(wfpa_pkg::OP_REQUEST, 4'h0, 16'd101);
      send_item(wfpa_pkg::OP_REQUEST, 4'h0, 16'd100);
      // alternating bit patterns in sizes and holes
      send_item(wfpa_pkg::OP_LOAD,    4'h7, 16'h5555);
      send_item(wfpa_pkg::OP_LOAD,    4'h8, 16'hAAAA);
      send_item(wfpa_pkg::OP_REQUEST, 4'h6, 16'h0001);
      send_item(wfpa_pkg::OP_REQUEST, 4'h9, 16'h5555);
      // reloading a used partition frees it again
      send_item(wfpa_pkg::OP_LOAD,    4'h8, 16'h1234);
      send_item(wfpa_pkg::OP_REQUEST, 4'h1, 16'h0234);
      // a few more indexes so that every index bit toggles
      send_item(wfpa_pkg::OP_LOAD,    4'hC, 16'h8000);
      send_item(wfpa_pkg::OP_LOAD,    4'hE, 16'h7FFF);
      send_item(wfpa_pkg::OP_REQUEST, 4'h3, 16'h7FFF);
      send_item(wfpa_pkg::OP_REQUEST, 4'hC, 16'h7FFF);
      send_item(wfpa_pkg::OP_REQUEST, 4'h2, 16'h0000);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         int before_count;
         before_count = items_sent;
         calm_phase = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 2))
            0: begin
               // fill every partition, then drain past empty
               for (int k = 0; k < NUM_BLOCKS; k++)
                  send_item(wfpa_pkg::OP_LOAD, BIDX_W'(k), pick_size());
               repeat (NUM_BLOCKS + 1)
                  send_item(wfpa_pkg::OP_REQUEST, BIDX_W'($urandom), pick_request());
            end
            1: begin
               repeat ($urandom_range(1, 6))
                  send_item(wfpa_pkg::OP_LOAD, BIDX_W'($urandom), pick_size());
               repeat ($urandom_range(1, 6))
                  send_item(wfpa_pkg::OP_REQUEST, BIDX_W'($urandom), pick_request());
            end
            default: begin
               repeat (12) begin
                  if ($urandom_range(0, 1) == 0)
                     send_item(wfpa_pkg::OP_LOAD, BIDX_W'($urandom), pick_size());
                  else
                     send_item(wfpa_pkg::OP_REQUEST, BIDX_W'($urandom), pick_request());
               end
            end
         endcase
         random_sent += items_sent - before_count;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      // wait for the last results, then let the pipeline settle
      while (outcomes_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d transactions: %0d loads, %0d grants, %0d refused requests",
               items_sent, loads_seen, grants_seen, refusals_seen);
      $display("gaps of 0 to 8 cycles on both channels, with gap-free stretches mixed in");
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
